FILE: hw/rtl/pia_pkg.sv
package pia_pkg;

  localparam int unsigned DATA_W       = 64;
  localparam int unsigned POS_W        = 16;
  localparam int unsigned EBITS_W      = 7;
  localparam int unsigned ECOUNT_W     = 17;
  localparam int unsigned OFF_W        = 6;
  // bit address of an element end: 65536 * 64 needs 23 bits
  localparam int unsigned BIT_W        = 23;
  localparam int unsigned WIDX_W       = BIT_W - OFF_W;
  localparam int unsigned CFG_ADDR_W   = 1;
  localparam int unsigned CFG_DATA_W   = 17;
  localparam int unsigned WORD_COUNT_DEF = 1024;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  localparam logic [EBITS_W-1:0] EBITS_MAX   = 7'd64;
  localparam logic [EBITS_W-1:0] EBITS_RESET = 7'd32;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] REG_ELEMENT_BITS  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ELEMENT_COUNT = 1'd1;

  typedef struct packed {
    logic                command;
    logic                flag;
    logic [WIDX_W-1:0]   widx;
    logic [OFF_W-1:0]    off;
    logic                split;
    logic [EBITS_W-1:0]  width;
    logic [DATA_W-1:0]   value;
  } entry_t;

  function automatic logic [DATA_W-1:0] width_mask(input logic [EBITS_W-1:0] w);
    logic [DATA_W-1:0] m;
    if (w >= EBITS_MAX) begin
      m = '1;
    end else begin
      m = (DATA_W'(1) << w) - DATA_W'(1);
    end
    return m;
  endfunction

endpackage

FILE: hw/rtl/pia_front.sv
module pia_front #(
  parameter int unsigned WORD_COUNT = pia_pkg::WORD_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pia_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [pia_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             command,
  input  logic [pia_pkg::POS_W-1:0]        position,
  input  logic [pia_pkg::DATA_W-1:0]       value,
  output pia_pkg::entry_t                  entry
);

  localparam logic [31:0] STORE_BITS = 32'(WORD_COUNT * 64);

  logic [pia_pkg::EBITS_W-1:0]  ebits_r, ebits_nxt;
  logic [pia_pkg::ECOUNT_W-1:0] ecount_r, ecount_nxt;
  logic [pia_pkg::EBITS_W-1:0]  w;
  logic [pia_pkg::BIT_W-1:0]    bit_addr;
  logic [pia_pkg::BIT_W-1:0]    end_bit;
  logic [pia_pkg::EBITS_W-1:0]  off_sum;
  logic                         past_count;
  logic                         past_store;

  always_comb begin
    ebits_nxt  = ebits_r;
    ecount_nxt = ecount_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        pia_pkg::REG_ELEMENT_BITS:  ebits_nxt  = cfg_wdata[pia_pkg::EBITS_W-1:0];
        pia_pkg::REG_ELEMENT_COUNT: ecount_nxt = cfg_wdata[pia_pkg::ECOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ebits_r  <= pia_pkg::EBITS_RESET;
      ecount_r <= '0;
    end else begin
      ebits_r  <= ebits_nxt;
      ecount_r <= ecount_nxt;
    end
  end

  // widths above 64 act as 64
  assign w = (ebits_r > pia_pkg::EBITS_MAX) ? pia_pkg::EBITS_MAX : ebits_r;

  always_comb begin
    bit_addr   = pia_pkg::BIT_W'(position) * pia_pkg::BIT_W'(w);
    end_bit    = bit_addr + pia_pkg::BIT_W'(w);
    off_sum    = pia_pkg::EBITS_W'({1'b0, bit_addr[pia_pkg::OFF_W-1:0]}) + w;
    past_count = pia_pkg::ECOUNT_W'(position) >= ecount_r;
    past_store = 32'(end_bit) > STORE_BITS;

    entry.command = command;
    entry.flag    = past_count | past_store;
    entry.widx    = bit_addr[pia_pkg::BIT_W-1:pia_pkg::OFF_W];
    entry.off     = bit_addr[pia_pkg::OFF_W-1:0];
    entry.split   = off_sum > pia_pkg::EBITS_MAX;
    entry.width   = w;
    entry.value   = value & pia_pkg::width_mask(w);
  end

endmodule

FILE: hw/rtl/pia_queue.sv
module pia_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pia_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output pia_pkg::entry_t head_entry
);

  pia_pkg::entry_t slots_r [pia_pkg::Q_DEPTH];
  logic [pia_pkg::Q_PTR_W-1:0] head_r, head_nxt;
  logic [pia_pkg::Q_PTR_W-1:0] tail_r, tail_nxt;
  logic [pia_pkg::Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = cnt_r == pia_pkg::Q_CNT_W'(pia_pkg::Q_DEPTH);
  assign valid      = cnt_r != '0;
  assign head_entry = slots_r[head_r];

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      tail_nxt = tail_r + 1'b1;
    end
    if (pop) begin
      head_nxt = head_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[tail_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/pia_back.sv
module pia_back #(
  parameter int unsigned WORD_COUNT = pia_pkg::WORD_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  pia_pkg::entry_t             q_entry,
  output logic                        q_pop,
  output logic                        clearing,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [pia_pkg::DATA_W-1:0]  out_tdata,
  output logic                        out_tuser
);

  localparam int unsigned ADDR_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_W0     = 3'd2;
  localparam logic [2:0] S_W1     = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [pia_pkg::DATA_W-1:0] words_r [WORD_COUNT];
  logic [pia_pkg::DATA_W-1:0] rd_data_r;
  logic                       rd_en, wr_en;
  logic [ADDR_W-1:0]          rd_addr, wr_addr;
  logic [pia_pkg::DATA_W-1:0] wr_data;

  logic [2:0]                 state_r, state_nxt;
  logic [ADDR_W-1:0]          clr_r, clr_nxt;
  pia_pkg::entry_t            cur_r, cur_nxt;
  logic [pia_pkg::DATA_W-1:0] lo_r, lo_nxt;
  logic [pia_pkg::DATA_W-1:0] res_r, res_nxt;
  logic                       res_flag_r, res_flag_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [pia_pkg::DATA_W-1:0] out_data_r, out_data_nxt;
  logic                       out_flag_r, out_flag_nxt;

  logic [pia_pkg::EBITS_W-1:0] hi_shift;
  logic [pia_pkg::DATA_W-1:0]  mask;
  logic [pia_pkg::DATA_W-1:0]  sh_lo, sh_hi, st_lo, st_hi;
  logic                        out_free;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      words_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= words_r[rd_addr];
    end
  end

  always_comb begin
    hi_shift = pia_pkg::EBITS_MAX - pia_pkg::EBITS_W'({1'b0, cur_r.off});
    mask     = pia_pkg::width_mask(cur_r.width);
    sh_lo    = rd_data_r >> cur_r.off;
    sh_hi    = rd_data_r << hi_shift;
    st_lo    = rd_data_r | (cur_r.value << cur_r.off);
    st_hi    = rd_data_r | (cur_r.value >> hi_shift);
    out_free = !out_valid_r || out_tready;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    lo_nxt        = lo_r;
    res_nxt       = res_r;
    res_flag_nxt  = res_flag_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_flag_nxt  = out_flag_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;

    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(WORD_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_entry;
          if (q_entry.flag) begin
            res_nxt      = '0;
            res_flag_nxt = 1'b1;
            state_nxt    = S_RESULT;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = ADDR_W'(q_entry.widx);
            state_nxt = S_W0;
          end
        end
      end
      S_W0: begin
        lo_nxt = sh_lo;
        if (cur_r.split) begin
          rd_en     = 1'b1;
          rd_addr   = ADDR_W'(cur_r.widx + pia_pkg::WIDX_W'(1));
          state_nxt = S_W1;
        end
        if (cur_r.command == pia_pkg::CMD_STORE) begin
          wr_en   = 1'b1;
          wr_addr = ADDR_W'(cur_r.widx);
          wr_data = st_lo;
          if (!cur_r.split) begin
            state_nxt = S_IDLE;
          end
        end else if (!cur_r.split) begin
          res_nxt      = sh_lo & mask;
          res_flag_nxt = 1'b0;
          state_nxt    = S_RESULT;
        end
      end
      S_W1: begin
        if (cur_r.command == pia_pkg::CMD_STORE) begin
          wr_en     = 1'b1;
          wr_addr   = ADDR_W'(cur_r.widx + pia_pkg::WIDX_W'(1));
          wr_data   = st_hi;
          state_nxt = S_IDLE;
        end else begin
          res_nxt      = (lo_r | sh_hi) & mask;
          res_flag_nxt = 1'b0;
          state_nxt    = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          out_flag_nxt  = res_flag_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    lo_r       <= lo_nxt;
    res_r      <= res_nxt;
    res_flag_r <= res_flag_nxt;
    out_data_r <= out_data_nxt;
    out_flag_r <= out_flag_nxt;
  end

  assign clearing   = state_r == S_CLEAR;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flag_r;

endmodule

FILE: hw/rtl/packed_integer_array_access.sv
// channel   dir  payload                                         handshake
// in_       in   tdata: position[15:0], value[79:16]; tuser: cmd  tvalid/tready
// out_      out  tdata: read_value[63:0]; tuser: out_of_range     tvalid/tready
// cfg_      in   cfg_addr 0 element_bits, 1 element_count          cfg_we, no wait
//
// In the word sequencer a flagged item passes IDLE and RESULT, a store IDLE and W0
// (and W1 if the element straddles two words), a load IDLE, W0 (W1 if straddling)
// and RESULT; the single read and single write port of the word memory set these steps.
// After reset the memory is zeroed one word a cycle, all WORD_COUNT words, with
// in_tready low. A two-entry queue lets the classifier take items while the
// sequencer works or the output register waits on out_tready.
module packed_integer_array_access #(
  parameter int unsigned WORD_COUNT = pia_pkg::WORD_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [79:0]                     in_tdata,  // position[15:0], value[79:16]
  input  logic                            in_tuser,  // command
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pia_pkg::DATA_W-1:0]      out_tdata, // read_value[63:0]
  output logic                            out_tuser, // out_of_range
  input  logic                            cfg_we,
  input  logic [pia_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [pia_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  pia_pkg::entry_t new_entry;
  pia_pkg::entry_t head_entry;
  logic            q_full, q_valid, q_pop, push, clearing;

  assign in_tready = !q_full && !clearing;
  assign push      = in_tvalid && in_tready;

  pia_front #(.WORD_COUNT(WORD_COUNT)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .command  (in_tuser),
    .position (in_tdata[pia_pkg::POS_W-1:0]),
    .value    (in_tdata[pia_pkg::POS_W+pia_pkg::DATA_W-1:pia_pkg::POS_W]),
    .entry    (new_entry)
  );

  pia_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(new_entry),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head_entry(head_entry)
  );

  pia_back #(.WORD_COUNT(WORD_COUNT)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (head_entry),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("flagged result carries nonzero data");

  a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_tready && !out_tvalid)
    else $error("item moved during clearing pass");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid && !clearing)
    else $error("queue popped while empty or clearing");

  a_result_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!clearing))
    else $error("result raised out of clearing pass");

endmodule

FILE: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pia_pkg::*;

  localparam int unsigned WORDS        = WORD_COUNT_DEF;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned QUIET_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              flag;
  } read_result_t;

  typedef struct {
    row_kind_t               kind;
    logic [CFG_ADDR_W-1:0]   addr;
    logic [CFG_DATA_W-1:0]   wdata;
    logic                    cmd;
    logic [POS_W-1:0]        pos;
    logic [DATA_W-1:0]       value;
    bit                      typed;
    read_result_t            result;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [79:0]           in_tdata;   // position[15:0], value[79:16]
  logic                  in_tuser;   // command
  logic                  out_tvalid;
  logic                  out_tready;
  logic [DATA_W-1:0]     out_tdata;  // read_value[63:0]
  logic                  out_tuser;  // out_of_range
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predictor state
  logic [DATA_W-1:0]   model_words [WORDS];
  logic [EBITS_W-1:0]  cur_elem_bits;
  logic [ECOUNT_W-1:0] cur_elem_count;

  read_result_t pending_reads[$];
  stim_row_t    stim_rows[$];
  int unsigned  items_sent;
  int unsigned  mismatches;
  int unsigned  cycle_count;
  bit           burst_mode;
  bit           hold_request;

  packed_integer_array_access #(
    .WORD_COUNT(WORDS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic stim_row_t item_row(logic cmd, logic [POS_W-1:0] pos,
                                         logic [DATA_W-1:0] value);
    stim_row_t r;
    r.kind   = ROW_ITEM;
    r.addr   = '0;
    r.wdata  = '0;
    r.cmd    = cmd;
    r.pos    = pos;
    r.value  = value;
    r.typed  = 1'b0;
    r.result = '0;
    return r;
  endfunction

  function automatic stim_row_t checked_row(logic cmd, logic [POS_W-1:0] pos,
                                            logic [DATA_W-1:0] value,
                                            logic [DATA_W-1:0] rd, logic flag);
    stim_row_t r;
    r = item_row(cmd, pos, value);
    r.typed        = 1'b1;
    r.result.value = rd;
    r.result.flag  = flag;
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_ADDR_W-1:0] addr,
                                        logic [CFG_DATA_W-1:0] wdata);
    stim_row_t r;
    r = item_row(CMD_LOAD, '0, '0);
    r.kind  = ROW_REG;
    r.addr  = addr;
    r.wdata = wdata;
    return r;
  endfunction

  // Load or OR-store one element of the packed word array.
  function automatic void apply_array_access(input logic cmd, input logic [POS_W-1:0] pos,
                                             input logic [DATA_W-1:0] value,
                                             output bit has_result,
                                             output read_result_t res);
    int unsigned       w;
    int unsigned       widx;
    int unsigned       off;
    longint unsigned   first_bit;
    longint unsigned   end_bit;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] r;
    bit                straddle;
    w = (cur_elem_bits > 7'd64) ? 64 : 32'(cur_elem_bits);
    first_bit = 64'(pos);
    first_bit = first_bit * w;
    end_bit = first_bit + w;
    has_result = 1'b1;
    res.value = '0;
    res.flag = 1'b1;
    if (pos >= cur_elem_count || end_bit > longint'(WORDS) * 64) return;
    res.flag = 1'b0;
    mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    widx = 32'(first_bit >> 6);
    off = 32'(first_bit & 64'd63);
    straddle = (off + w) > 64;
    if (cmd == CMD_LOAD) begin
      if (w != 0) begin
        r = model_words[widx] >> off;
        if (straddle) r |= model_words[widx + 1] << (64 - off);
        res.value = r & mask;
      end
    end else begin
      has_result = 1'b0;
      if (w != 0) begin
        v = value & mask;
        model_words[widx] |= v << off;
        if (straddle) model_words[widx + 1] |= v >> (64 - off);
      end
    end
  endfunction

  function automatic int pick_gap();
    int k;
    if (burst_mode) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void log_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, what);
  endfunction

  task automatic send_item(input logic cmd, input logic [POS_W-1:0] pos,
                           input logic [DATA_W-1:0] value, input bit typed,
                           input read_result_t typed_result);
    bit           has_result;
    read_result_t res;
    int           gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {value, pos};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    apply_array_access(cmd, pos, value, has_result, res);
    if (typed) pending_reads.push_back(typed_result);
    else if (has_result) pending_reads.push_back(res);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, drain all results, then let in-flight stores finish.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] wdata);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= wdata;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == REG_ELEMENT_BITS) cur_elem_bits = wdata[EBITS_W-1:0];
    else cur_elem_count = wdata[ECOUNT_W-1:0];
    @(posedge clk);
  endtask

  task automatic random_phase(input int n, input bit hold);
    int unsigned         w;
    int unsigned         pick;
    int unsigned         cnt;
    int unsigned         limit_pos;
    int unsigned         valid_max;
    int unsigned         base;
    int unsigned         span;
    int unsigned         pos;
    logic [EBITS_W-1:0]  bits;
    logic [ECOUNT_W-1:0] count;
    logic [DATA_W-1:0]   value;
    logic                cmd;
    pick = $urandom_range(0, 19);
    case (pick)
      0: bits = 7'd0;
      1: bits = 7'd1;
      2, 3: bits = 7'd64;
      4: bits = EBITS_W'($urandom_range(65, 127));
      default: bits = EBITS_W'($urandom_range(2, 63));
    endcase
    pick = $urandom_range(0, 9);
    if (pick == 0) count = '0;
    else if (pick == 1) count = 17'h10000;
    else if (pick == 2) count = ECOUNT_W'($urandom_range(65537, 131071));
    else if (pick < 6) count = ECOUNT_W'($urandom_range(1, 65535));
    else count = ECOUNT_W'($urandom_range(1, 4096));
    settle();
    write_reg(REG_ELEMENT_BITS, {10'($urandom_range(0, 1023)), bits});
    write_reg(REG_ELEMENT_COUNT, count);
    // start the long receiver hold-off while this phase keeps offering items
    if (hold) hold_request = 1'b1;
    w = (bits > 7'd64) ? 64 : 32'(bits);
    cnt = 32'(count);
    limit_pos = (w == 0) ? 65535 : 65536 / w - 1;
    valid_max = (cnt != 0 && cnt - 1 < limit_pos) ? cnt - 1 : limit_pos;
    // keep accesses inside a small window so loads hit earlier stores
    base = $urandom_range(0, valid_max);
    span = $urandom_range(0, 31);
    burst_mode = ($urandom_range(0, 3) == 0);
    repeat (n) begin
      cmd = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (cnt != 0 && pick < 8) begin
        pos = base + $urandom_range(0, span);
        if (pos > valid_max) pos = valid_max;
      end else if (cnt != 0 && pick == 8) begin
        pos = valid_max + $urandom_range(0, 2);
        if (pos > 65535) pos = 65535;
      end else begin
        pos = $urandom_range(0, 65535);
      end
      pick = $urandom_range(0, 7);
      case (pick)
        0: value = '1;
        1: value = 64'd1 << $urandom_range(0, 63);
        2: value = DATA_W'($urandom_range(0, 255));
        default: value = {$urandom, $urandom};
      endcase
      send_item(cmd, POS_W'(pos), value, 1'b0, '0);
    end
  endtask

  // receiver: random stalls, bursts of steady ready, one long hold-off
  initial begin
    int len;
    int k;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        k = $urandom_range(0, 99);
        if (k < 55) begin
          out_tready <= 1'b1;
          len = $urandom_range(1, 12);
        end else if (k < 70) begin
          out_tready <= 1'b1;
          len = $urandom_range(50, 150);
        end else if (k < 93) begin
          out_tready <= 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          out_tready <= 1'b0;
          len = $urandom_range(15, 60);
        end
        repeat (len - 1) begin
          if (hold_request) break;
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    read_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reads.size() == 0) begin
        log_mismatch($sformatf("unexpected result: value %h flag %b", out_tdata, out_tuser));
      end else begin
        want = pending_reads.pop_front();
        if (out_tdata !== want.value || out_tuser !== want.flag)
          log_mismatch($sformatf("expected value %h flag %b, got value %h flag %b",
                                 want.value, want.flag, out_tdata, out_tuser));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned random_start;
    int unsigned phase_idx;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    cycle_count  = 0;
    items_sent   = 0;
    mismatches   = 0;
    burst_mode   = 1'b0;
    hold_request = 1'b0;
    foreach (model_words[i]) model_words[i] = '0;
    cur_elem_bits  = EBITS_RESET;
    cur_elem_count = '0;

    // after reset the count is zero, so everything is flagged
    stim_rows.push_back(checked_row(CMD_LOAD, 0, '0, '0, 1'b1));
    stim_rows.push_back(checked_row(CMD_STORE, 0, '1, '0, 1'b1));
    stim_rows.push_back(reg_row(REG_ELEMENT_BITS, 17'd64));
    stim_rows.push_back(reg_row(REG_ELEMENT_COUNT, 17'h10000));
    stim_rows.push_back(item_row(CMD_STORE, 0, '1));
    stim_rows.push_back(checked_row(CMD_LOAD, 0, '0, '1, 1'b0));
    stim_rows.push_back(checked_row(CMD_LOAD, 1023, '0, '0, 1'b0));
    stim_rows.push_back(item_row(CMD_STORE, 1023, 64'h8000_0000_0000_0001));
    stim_rows.push_back(checked_row(CMD_LOAD, 1023, '1, 64'h8000_0000_0000_0001, 1'b0));
    // element end past the storage
    stim_rows.push_back(checked_row(CMD_LOAD, 1024, '0, '0, 1'b1));
    stim_rows.push_back(checked_row(CMD_STORE, 65535, '1, '0, 1'b1));
    stim_rows.push_back(reg_row(REG_ELEMENT_BITS, 17'd1));
    stim_rows.push_back(item_row(CMD_STORE, 65535, 64'd1));
    stim_rows.push_back(checked_row(CMD_LOAD, 65535, '0, 64'd1, 1'b0));
    stim_rows.push_back(item_row(CMD_STORE, 128, 64'hFFFF_FFFF_FFFF_FFFE));
    stim_rows.push_back(checked_row(CMD_LOAD, 128, '0, '0, 1'b0));
    // empty elements
    stim_rows.push_back(reg_row(REG_ELEMENT_BITS, 17'd0));
    stim_rows.push_back(checked_row(CMD_LOAD, 5, '0, '0, 1'b0));
    stim_rows.push_back(item_row(CMD_STORE, 5, 64'hFF));
    stim_rows.push_back(checked_row(CMD_LOAD, 65535, '0, '0, 1'b0));
    // width above 64 acts as 64, count above 65536
    stim_rows.push_back(reg_row(REG_ELEMENT_BITS, 17'd100));
    stim_rows.push_back(reg_row(REG_ELEMENT_COUNT, 17'h1FFFF));
    stim_rows.push_back(checked_row(CMD_LOAD, 0, '0, '1, 1'b0));
    stim_rows.push_back(checked_row(CMD_LOAD, 1024, '0, '0, 1'b1));
    stim_rows.push_back(item_row(CMD_STORE, 1023, 64'h0F0));
    stim_rows.push_back(item_row(CMD_LOAD, 1023, '0));
    // upper register bits ignored; element 4 straddles words 0 and 1
    stim_rows.push_back(reg_row(REG_ELEMENT_BITS, 17'h1FF8D));
    stim_rows.push_back(reg_row(REG_ELEMENT_COUNT, 17'd10));
    stim_rows.push_back(item_row(CMD_STORE, 9, 64'h1234_5678_9ABC_DEF0));
    stim_rows.push_back(item_row(CMD_LOAD, 9, '0));
    stim_rows.push_back(checked_row(CMD_LOAD, 10, '0, '0, 1'b1));
    stim_rows.push_back(item_row(CMD_STORE, 4, '1));
    stim_rows.push_back(item_row(CMD_LOAD, 4, '0));
    stim_rows.push_back(checked_row(CMD_STORE, 65535, '0, '0, 1'b1));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_REG) begin
        settle();
        write_reg(stim_rows[i].addr, stim_rows[i].wdata);
      end else begin
        send_item(stim_rows[i].cmd, stim_rows[i].pos, stim_rows[i].value,
                  stim_rows[i].typed, stim_rows[i].result);
      end
    end

    random_start = items_sent;
    phase_idx = 0;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      random_phase($urandom_range(20, 50), phase_idx == 2);
      phase_idx++;
    end

    settle();
    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
